// ----- src/fdag_pkg.sv -----
// fdag_pkg: shared types, constants and mode tables for the frequency
// deinterleaver address generator
// no dependencies
`default_nettype none
package fdag_pkg;

	localparam int MAX_DEGREE = 14;
	localparam int MAX_POINTS = 32768;

	localparam int PN_W   = 14;
	localparam int IDX_W  = 16;
	localparam int OUT_W  = 15;
	localparam int H_W    = 17;
	localparam int PERM_W = 56;
	localparam int DEG_W  = 4;

	localparam int APB_AW = 5;
	localparam int APB_DW = 64;

	localparam logic [2:0] FFT_1K  = 3'd0;
	localparam logic [2:0] FFT_2K  = 3'd1;
	localparam logic [2:0] FFT_4K  = 3'd2;
	localparam logic [2:0] FFT_8K  = 3'd3;
	localparam logic [2:0] FFT_16K = 3'd4;
	localparam logic [2:0] FFT_32K = 3'd5;

	localparam logic [1:0] REG_FFT_SIZE      = 2'd0;
	localparam logic [1:0] REG_CARRIER_COUNT = 2'd1;
	localparam logic [1:0] REG_PERM_EVEN     = 2'd2;
	localparam logic [1:0] REG_PERM_ODD      = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [1:0] {
		OUT_RESTART,
		OUT_EXHAUST,
		OUT_ENTRY
	} out_kind_t;

	typedef struct packed {
		logic [2:0]        fft_size;
		logic [15:0]       carrier_count;
		logic [PERM_W-1:0] perm_even;
		logic [PERM_W-1:0] perm_odd;
	} cfg_t;

	typedef struct packed {
		logic      accept;
		logic      clear;
		logic      advance;
		logic      out_load;
		out_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic restart;
		logic exhausted;
		logic hit;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [PN_W-1:0] tap_mask(input logic [2:0] mode);
		logic [PN_W-1:0] m;
		case (mode)
			FFT_1K:  m = 14'h0011;
			FFT_2K:  m = 14'h0009;
			FFT_4K:  m = 14'h0005;
			FFT_8K:  m = 14'h0053;
			FFT_16K: m = 14'h0a33;
			FFT_32K: m = 14'h1007;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [PN_W-1:0] reg_mask(input logic [2:0] mode);
		logic [PN_W-1:0] m;
		case (mode)
			FFT_1K:  m = 14'h01ff;
			FFT_2K:  m = 14'h03ff;
			FFT_4K:  m = 14'h07ff;
			FFT_8K:  m = 14'h0fff;
			FFT_16K: m = 14'h1fff;
			FFT_32K: m = 14'h3fff;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic mode_ok(input logic [2:0] mode);
		int unsigned deg;
		int unsigned sz;
		deg = 9 + int'(mode);
		sz  = 32'd1024 << mode;
		return (mode <= FFT_32K) && (deg <= MAX_DEGREE) && (sz <= MAX_POINTS);
	endfunction

	function automatic logic [DEG_W-1:0] mode_degree(input logic [2:0] mode);
		logic [DEG_W-1:0] d;
		d = '0;
		if (mode_ok(mode)) begin
			d = DEG_W'(4'd9 + DEG_W'(mode));
		end
		return d;
	endfunction

	function automatic logic [IDX_W-1:0] mode_size(input logic [2:0] mode);
		logic [IDX_W-1:0] s;
		s = '0;
		if (mode_ok(mode)) begin
			s = IDX_W'(17'd1024 << mode);
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- src/freq_deinterleave_address_gen.sv -----
// freq_deinterleave_address_gen: top level, apb registers, controller and datapath
// depends on fdag_pkg, fdag_cfg, fdag_ctrl, fdag_dp
//
// Each input item is a command: restart (clear the sequence) or next (walk the
// pn candidate sequence of the selected fft mode up to the next candidate whose
// permuted address is below carrier_count). Every command yields one result item
// with table address, table value, an entry flag and a last flag. The datapath
// examines one candidate per clock, skipping candidates until the entry is found
// or the sequence runs out; a restart clears the sequence instead. While the
// previous result is still held back by m_tready, a new result is not loaded and
// the controller stays in its run state.
// The input is accepted only when the controller is idle; the output register
// lets the next item in while a result still waits, and a found entry waits
// there only if the previous result has not been taken. Configuration should be
// written only while no command is in progress.
`default_nettype none
module freq_deinterleave_address_gen (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fdag_pkg::APB_AW-1:0] paddr,
	input  wire logic [fdag_pkg::APB_DW-1:0] pwdata,
	output logic      [fdag_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,  // cmd, zero pad
	input  wire logic [0:0]                  s_tuser,  // symbol_parity
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [31:0]                      m_tdata,  // table_address, table_value, zero pad
	output logic [0:0]                       m_tuser,  // valid_res
	output logic                             m_tlast
);

	fdag_pkg::cfg_t     cfg;
	fdag_pkg::dp_cmd_t  cmd;
	fdag_pkg::dp_stat_t stat;

	fdag_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fdag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fdag_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.in_cmd    (s_tdata[0]),
		.in_parity (s_tuser[0]),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ----- src/fdag_cfg.sv -----
// fdag_cfg: apb configuration registers of the address generator
// depends on fdag_pkg
`default_nettype none
module fdag_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fdag_pkg::APB_AW-1:0]   paddr,
	input  wire logic [fdag_pkg::APB_DW-1:0]   pwdata,
	output logic      [fdag_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output fdag_pkg::cfg_t                     cfg
);

	logic [2:0]                  fft_size_q;
	logic [15:0]                 carrier_count_q;
	logic [fdag_pkg::PERM_W-1:0] perm_even_q;
	logic [fdag_pkg::PERM_W-1:0] perm_odd_q;
	logic [1:0]                  reg_idx;
	logic                        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_size_q      <= '0;
			carrier_count_q <= '0;
			perm_even_q     <= '0;
			perm_odd_q      <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				fdag_pkg::REG_FFT_SIZE:      fft_size_q      <= pwdata[2:0];
				fdag_pkg::REG_CARRIER_COUNT: carrier_count_q <= pwdata[15:0];
				fdag_pkg::REG_PERM_EVEN:     perm_even_q     <= pwdata[fdag_pkg::PERM_W-1:0];
				fdag_pkg::REG_PERM_ODD:      perm_odd_q      <= pwdata[fdag_pkg::PERM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fdag_pkg::REG_FFT_SIZE:      prdata = 64'(fft_size_q);
			fdag_pkg::REG_CARRIER_COUNT: prdata = 64'(carrier_count_q);
			fdag_pkg::REG_PERM_EVEN:     prdata = 64'(perm_even_q);
			fdag_pkg::REG_PERM_ODD:      prdata = 64'(perm_odd_q);
			default:                     prdata = '0;
		endcase
	end

	always_comb begin
		cfg.fft_size      = fft_size_q;
		cfg.carrier_count = carrier_count_q;
		cfg.perm_even     = perm_even_q;
		cfg.perm_odd      = perm_odd_q;
	end

endmodule
`default_nettype wire

// ----- src/fdag_ctrl.sv -----
// fdag_ctrl: controller state machine, walks candidates one per cycle
// depends on fdag_pkg
`default_nettype none
module fdag_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire fdag_pkg::dp_stat_t stat,
	output fdag_pkg::dp_cmd_t       cmd
);

	fdag_pkg::state_t state_q;
	fdag_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdag_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.clear    = 1'b0;
		cmd.advance  = 1'b0;
		cmd.out_load = 1'b0;
		cmd.kind     = fdag_pkg::OUT_RESTART;
		case (state_q)
			fdag_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_nxt  = fdag_pkg::ST_RUN;
				end
			end
			fdag_pkg::ST_RUN: begin
				if (stat.restart) begin
					if (!stat.out_busy) begin
						cmd.clear    = 1'b1;
						cmd.out_load = 1'b1;
						cmd.kind     = fdag_pkg::OUT_RESTART;
						state_nxt    = fdag_pkg::ST_IDLE;
					end
				end else if (stat.exhausted) begin
					if (!stat.out_busy) begin
						cmd.out_load = 1'b1;
						cmd.kind     = fdag_pkg::OUT_EXHAUST;
						state_nxt    = fdag_pkg::ST_IDLE;
					end
				end else if (stat.hit) begin
					if (!stat.out_busy) begin
						cmd.advance  = 1'b1;
						cmd.out_load = 1'b1;
						cmd.kind     = fdag_pkg::OUT_ENTRY;
						state_nxt    = fdag_pkg::ST_IDLE;
					end
				end else begin
					// skipped candidate
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_nxt = fdag_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/fdag_dp.sv -----
// fdag_dp: datapath with pn register, candidate and entry counters,
// bit permutation, carrier compare and the output register
// depends on fdag_pkg
`default_nettype none
module fdag_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fdag_pkg::cfg_t      cfg,
	input  wire fdag_pkg::dp_cmd_t   cmd,
	input  wire logic                in_cmd,
	input  wire logic                in_parity,
	output fdag_pkg::dp_stat_t       stat,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [31:0]              m_tdata,  // table_address, table_value, zero pad
	output logic [0:0]               m_tuser,  // valid_res
	output logic                     m_tlast
);

	localparam int PN_W  = fdag_pkg::PN_W;
	localparam int IDX_W = fdag_pkg::IDX_W;
	localparam int OUT_W = fdag_pkg::OUT_W;
	localparam int H_W   = fdag_pkg::H_W;

	logic                        restart_q;
	logic                        parity_q;
	logic [PN_W-1:0]             pn_q;
	logic [IDX_W-1:0]            idx_q;
	logic [OUT_W-1:0]            oidx_q;
	logic                        out_valid_q;
	logic                        out_res_q;
	logic                        out_last_q;
	logic [OUT_W-1:0]            out_addr_q;
	logic [OUT_W-1:0]            out_val_q;

	logic [2:0]                  mode;
	logic [fdag_pkg::DEG_W-1:0]  degree;
	logic [IDX_W-1:0]            size;
	logic [fdag_pkg::PERM_W-1:0] perm;
	logic                        fb;
	logic [PN_W-1:0]             pn_step;
	logic [PN_W-1:0]             pn_nxt;
	logic [15:0]                 perm_r;
	logic [H_W-1:0]              h;
	logic [IDX_W-1:0]            idx_inc;
	logic                        swap;

	assign mode    = cfg.fft_size;
	assign degree  = fdag_pkg::mode_degree(mode);
	assign size    = fdag_pkg::mode_size(mode);
	assign perm    = (mode == fdag_pkg::FFT_32K || !parity_q) ? cfg.perm_even : cfg.perm_odd;
	assign fb      = ^(pn_q & fdag_pkg::tap_mask(mode));
	assign pn_step = ((pn_q & fdag_pkg::reg_mask(mode)) >> 1)
	               | (PN_W'(fb) << (degree - 4'd1));
	assign idx_inc = idx_q + 16'd1;
	assign swap    = (mode == fdag_pkg::FFT_32K) && !parity_q;

	always_comb begin
		if (idx_q < 16'd2) begin
			pn_nxt = '0;
		end else if (idx_q == 16'd2) begin
			pn_nxt = 14'd1;
		end else begin
			pn_nxt = pn_step;
		end
	end

	always_comb begin
		perm_r = '0;
		for (int n = 0; n < PN_W; n++) begin
			if (n < int'(degree)) begin
				perm_r = perm_r | (16'(pn_nxt[n]) << perm[4*n +: 4]);
			end
		end
	end

	assign h = H_W'(perm_r) + (H_W'(idx_q[0]) << degree);

	always_comb begin
		stat.restart   = !restart_q;
		stat.exhausted = idx_q >= size;
		stat.hit       = h < H_W'(cfg.carrier_count);
		stat.out_busy  = out_valid_q && !m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b0;
			parity_q  <= 1'b0;
		end else if (cmd.accept) begin
			restart_q <= in_cmd;
			parity_q  <= in_parity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q   <= '0;
			idx_q  <= '0;
			oidx_q <= '0;
		end else if (cmd.clear) begin
			pn_q   <= '0;
			idx_q  <= '0;
			oidx_q <= '0;
		end else if (cmd.advance) begin
			pn_q  <= pn_nxt;
			idx_q <= idx_inc;
			if (cmd.out_load) begin
				oidx_q <= oidx_q + 15'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.kind)
				fdag_pkg::OUT_ENTRY: begin
					out_res_q  <= 1'b1;
					out_last_q <= idx_inc >= size;
					out_addr_q <= swap ? oidx_q : h[OUT_W-1:0];
					out_val_q  <= swap ? h[OUT_W-1:0] : oidx_q;
				end
				fdag_pkg::OUT_EXHAUST: begin
					out_res_q  <= 1'b0;
					out_last_q <= 1'b1;
					out_addr_q <= '0;
					out_val_q  <= '0;
				end
				default: begin
					out_res_q  <= 1'b0;
					out_last_q <= 1'b0;
					out_addr_q <= '0;
					out_val_q  <= '0;
				end
			endcase
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {2'b00, out_val_q, out_addr_q};
	assign m_tuser[0] = out_res_q;
	assign m_tlast    = out_last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !m_tready))
		else $error("result loaded over an untaken item");

	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.kind == fdag_pkg::OUT_ENTRY) |=> (oidx_q == $past(oidx_q) + 15'd1))
		else $error("entry counter did not step with an entry");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (pn_q == '0 && idx_q == '0 && oidx_q == '0))
		else $error("restart left sequence state");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_res_q) |-> (out_addr_q == '0 && out_val_q == '0))
		else $error("item without entry carries nonzero fields");

endmodule
`default_nettype wire

// ----- tb/fdag_checker.sv -----
// fdag_checker: watches the apb, command and result channels of the frequency
// deinterleaver address generator, predicts every result item and compares it
// depends on fdag_pkg
`default_nettype none
module fdag_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [fdag_pkg::APB_AW-1:0] paddr,
	input  wire logic [fdag_pkg::APB_DW-1:0] pwdata,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [7:0]                  s_tdata,  // cmd, zero pad
	input  wire logic [0:0]                  s_tuser,  // symbol_parity
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [31:0]                 m_tdata,  // table_address, table_value, zero pad
	input  wire logic [0:0]                  m_tuser,  // valid_res
	input  wire logic                        m_tlast,
	output int                               mismatches,
	output int                               entries_due
);
	import fdag_pkg::*;

	typedef struct packed {
		logic        valid;
		logic [14:0] addr;
		logic [14:0] data;
		logic        is_last;
	} tbl_entry_t;

	logic [2:0]  cfg_mode;
	logic [15:0] cfg_carriers;
	logic [55:0] cfg_perm_even;
	logic [55:0] cfg_perm_odd;

	logic [13:0] pn;
	logic [15:0] cand_idx;
	logic [14:0] entry_idx;

	tbl_entry_t pending_entries[$];
	int         err_count;

	function automatic logic [13:0] taps_of(input logic [2:0] mode);
		logic [13:0] t;
		case (mode)
			FFT_1K:  t = 14'b00_0000_0001_0001;
			FFT_2K:  t = 14'b00_0000_0000_1001;
			FFT_4K:  t = 14'b00_0000_0000_0101;
			FFT_8K:  t = 14'b00_0000_0101_0011;
			FFT_16K: t = 14'b00_1010_0011_0011;
			FFT_32K: t = 14'b01_0000_0000_0111;
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic int unsigned scatter_bits(input logic [13:0] v, input logic [55:0] perm,
			input int unsigned deg);
		int unsigned r;
		r = 0;
		for (int n = 0; n < deg; n++) begin
			if (v[n]) begin
				r = r | (32'd1 << perm[4*n +: 4]);
			end
		end
		return r;
	endfunction

	// clears the sequence on restart, else walks it up to the next carrier below carrier_count
	task automatic next_table_entry(input logic cmd, input logic odd_sym, output tbl_entry_t e);
		int unsigned deg;
		int unsigned npts;
		int unsigned i;
		int unsigned h;
		logic [55:0] perm;
		logic        fb;
		logic        found;
		e = '0;
		found = 1'b0;
		if (!cmd) begin
			pn = '0;
			cand_idx = '0;
			entry_idx = '0;
		end else begin
			deg = 0;
			npts = 0;
			if (cfg_mode <= FFT_32K && 9 + cfg_mode <= MAX_DEGREE &&
					(32'd1024 << cfg_mode) <= MAX_POINTS) begin
				deg = 9 + cfg_mode;
				npts = 32'd1024 << cfg_mode;
			end
			perm = (cfg_mode == FFT_32K || !odd_sym) ? cfg_perm_even : cfg_perm_odd;
			while (!found && cand_idx < npts) begin
				i = cand_idx;
				if (i < 2) begin
					pn = '0;
				end else if (i == 2) begin
					pn = 14'd1;
				end else begin
					fb = ^(pn & taps_of(cfg_mode));
					pn = ((pn & 14'((32'd1 << deg) - 1)) >> 1) | (14'(fb) << (deg - 1));
				end
				h = scatter_bits(pn, perm, deg) + ((i & 1) << deg);
				cand_idx = 16'(i + 1);
				if (h < cfg_carriers) begin
					found = 1'b1;
					e.valid = 1'b1;
					if (cfg_mode == FFT_32K && !odd_sym) begin
						e.addr = entry_idx;
						e.data = 15'(h);
					end else begin
						e.addr = 15'(h);
						e.data = entry_idx;
					end
					e.is_last = (cand_idx >= npts);
					entry_idx = entry_idx + 15'd1;
				end
			end
			if (!found) begin
				e.is_last = 1'b1;
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tbl_entry_t want_e;
		tbl_entry_t new_e;
		if (!arst_n) begin
			cfg_mode = FFT_1K;
			cfg_carriers = '0;
			cfg_perm_even = '0;
			cfg_perm_odd = '0;
			pn = '0;
			cand_idx = '0;
			entry_idx = '0;
			pending_entries.delete();
			err_count = 0;
			mismatches <= 0;
			entries_due <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_FFT_SIZE:      cfg_mode = pwdata[2:0];
					REG_CARRIER_COUNT: cfg_carriers = pwdata[15:0];
					REG_PERM_EVEN:     cfg_perm_even = pwdata[55:0];
					REG_PERM_ODD:      cfg_perm_odd = pwdata[55:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (pending_entries.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result item, expected none actual tdata %0h user %0b last %0b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want_e = pending_entries.pop_front();
					compare_field("valid_res", 32'(want_e.valid), 32'(m_tuser[0]));
					compare_field("table_address", 32'(want_e.addr), 32'(m_tdata[14:0]));
					compare_field("table_value", 32'(want_e.data), 32'(m_tdata[29:15]));
					compare_field("last", 32'(want_e.is_last), 32'(m_tlast));
					compare_field("tdata pad", 32'd0, 32'(m_tdata[31:30]));
				end
			end
			if (s_tvalid && s_tready) begin
				next_table_entry(s_tdata[0], s_tuser[0], new_e);
				pending_entries.push_back(new_e);
			end
			mismatches <= err_count;
			entries_due <= pending_entries.size();
		end
	end

endmodule
`default_nettype wire

// ----- tb/freq_deinterleave_address_gen_tb.sv -----
// freq_deinterleave_address_gen_tb: drives apb setup, command items and result
// backpressure, directed cases first and then random phases; gives the verdict
// depends on fdag_pkg, fdag_checker and freq_deinterleave_address_gen
`default_nettype none
module freq_deinterleave_address_gen_tb;
	import fdag_pkg::*;

	localparam int          TOTAL_ITEMS = 1325;
	localparam int          CYCLE_LIMIT = 20000000;
	localparam logic [55:0] PERM_IDENT  = 56'hdc_ba98_7654_3210;
	localparam logic [55:0] PERM_HIGH   = 56'hff_ffff_ffff_ffff;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic [0:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;
	logic [0:0]        m_tuser;
	logic              m_tlast;

	int mismatches;
	int entries_due;
	int cycles = 0;
	int items_sent = 0;
	int tready_hold;
	int stall_draw;
	bit no_idle = 1'b0;

	freq_deinterleave_address_gen u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	fdag_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.entries_due (entries_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			tready_hold <= 0;
		end else if (m_tready && m_tvalid) begin
			stall_draw = no_idle ? 0 : $urandom_range(0, 10);
			if (stall_draw == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				tready_hold <= stall_draw;
			end
		end else if (!m_tready) begin
			if (tready_hold <= 1) begin
				m_tready <= 1'b1;
			end
			if (tready_hold > 0) begin
				tready_hold <= tready_hold - 1;
			end
		end
	end

	task automatic apb_write(input logic [1:0] reg_sel, input logic [63:0] wval);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 3'b000};
		pwdata <= wval;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input logic cmd, input logic parity);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, cmd};
		s_tuser <= parity;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// wait until every result is back and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (entries_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input logic [2:0] mode, input logic [15:0] carriers,
			input logic [55:0] pe, input logic [55:0] po);
		settle();
		apb_write(REG_FFT_SIZE, 64'(mode));
		apb_write(REG_CARRIER_COUNT, 64'(carriers));
		apb_write(REG_PERM_EVEN, 64'(pe));
		apb_write(REG_PERM_ODD, 64'(po));
	endtask

	// mostly a true bit permutation over the active degree, sometimes raw noise
	function automatic logic [55:0] draw_perm(input int deg);
		logic [55:0] p;
		int          pos[14];
		int          d;
		int          j;
		int          t;
		p = '0;
		d = (deg > 14) ? 14 : deg;
		if ($urandom_range(0, 9) < 3) begin
			return 56'({$urandom, $urandom});
		end
		for (int n = 0; n < 14; n++) begin
			pos[n] = (n < d) ? n : $urandom_range(0, 15);
		end
		for (int n = d - 1; n > 0; n--) begin
			j = $urandom_range(0, n);
			t = pos[n];
			pos[n] = pos[j];
			pos[j] = t;
		end
		for (int n = 0; n < 14; n++) begin
			p[4*n +: 4] = 4'(pos[n]);
		end
		return p;
	endfunction

	task automatic run_phase();
		logic [2:0]  mode;
		logic [15:0] carriers;
		int          pick;
		int          npts;
		int          n_items;
		int          span;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			mode = FFT_1K;
		end else if (pick < 60) begin
			mode = FFT_2K;
		end else if (pick < 72) begin
			mode = FFT_4K;
		end else if (pick < 82) begin
			mode = FFT_8K;
		end else if (pick < 90) begin
			mode = FFT_16K;
		end else if (pick < 97) begin
			mode = FFT_32K;
		end else begin
			mode = FFT_32K + 3'($urandom_range(1, 2));
		end
		npts = (mode <= FFT_32K) ? (1024 << mode) : 1024;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			carriers = (mode <= FFT_2K) ? 16'd0 : 16'(npts);
		end else if (pick == 1) begin
			carriers = 16'hffff;
		end else if (pick == 2) begin
			carriers = 16'h8000;
		end else if (pick == 3) begin
			carriers = (mode <= FFT_2K) ? 16'($urandom_range(1, 64)) : 16'(npts);
		end else if (pick < 7) begin
			carriers = 16'(npts);
		end else begin
			span = $urandom_range(npts / 2, 2 * npts);
			carriers = (span > 65535) ? 16'hffff : 16'(span);
		end
		no_idle = ($urandom_range(0, 3) == 0);
		configure(mode, carriers, draw_perm(9 + mode), draw_perm(9 + mode));
		n_items = $urandom_range(10, 80);
		if ($urandom_range(0, 1)) begin
			send_item(1'b0, 1'($urandom_range(0, 1)));
		end
		repeat (n_items) begin
			send_item($urandom_range(0, 29) != 0, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no carriers, so the sequence runs out
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b0);

		// only pn states 0 and 2 land low: candidates 0, 1, 512 and the final one
		configure(FFT_1K, 16'h0400, 56'hff_ffff_ffff_ff0f, PERM_IDENT);
		repeat (5) send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b1);
		send_item(1'b1, 1'b1);

		// 32k swaps address and value on even symbols, odd symbols still use perm_even
		configure(FFT_32K, 16'h8000, PERM_IDENT, PERM_HIGH);
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b1, 1'b1);

		// 2k run parked past candidate 1024, then the mode shrinks under it
		configure(FFT_2K, 16'h8000, 56'hff_ffff_ffff_fff0, PERM_IDENT);
		send_item(1'b0, 1'b0);
		repeat (4) send_item(1'b1, 1'b0);
		settle();
		apb_write(REG_FFT_SIZE, 64'(FFT_1K));
		send_item(1'b1, 1'b0);

		// unsupported modes
		settle();
		apb_write(REG_FFT_SIZE, 64'(FFT_32K + 3'd1));
		send_item(1'b1, 1'b1);
		settle();
		apb_write(REG_FFT_SIZE, 64'(FFT_32K + 3'd2));
		send_item(1'b1, 1'b0);

		configure(FFT_4K, 16'hffff, PERM_HIGH, 56'({$urandom, $urandom}));
		send_item(1'b1, 1'b1);

		while (items_sent < TOTAL_ITEMS) begin
			run_phase();
		end

		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
